FILE: rtl/core/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared types, widths and constants for the depth pixel back-projection unit.
// ----------------------------------------------------------------------------
package dpb_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;
    localparam int COLOR_BITS = 8;
    localparam int FOCAL_W    = 16;
    localparam int POINT_W    = 32;
    localparam int FRAC_BITS  = 4;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;

    localparam int SCALED_W   = COORD_BITS + FRAC_BITS;
    localparam int DIFF_W     = ((SCALED_W > FOCAL_W) ? SCALED_W : FOCAL_W) + 1;
    localparam int MAG_W      = DIFF_W - 1;
    localparam int PROD_W     = MAG_W + DEPTH_BITS;
    localparam int DIVIDEND_W = PROD_W + FRAC_BITS;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int SAT_W      = (DIVIDEND_W > POINT_W) ? DIVIDEND_W : POINT_W + 1;

    localparam logic [POINT_W-1:0] POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic [POINT_W-1:0] POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};

    localparam logic [FOCAL_W-1:0] FOCAL_X_RESET  = FOCAL_W'(9600);
    localparam logic [FOCAL_W-1:0] FOCAL_Y_RESET  = FOCAL_W'(9600);
    localparam logic [FOCAL_W-1:0] CENTER_X_RESET = FOCAL_W'(5120);
    localparam logic [FOCAL_W-1:0] CENTER_Y_RESET = FOCAL_W'(3840);

    typedef enum logic [1:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTER_X,
        REG_CENTER_Y
    } dpb_reg_index_t;

    typedef struct packed {
        logic [FOCAL_W-1:0] focal_x;
        logic [FOCAL_W-1:0] focal_y;
        logic [FOCAL_W-1:0] center_x;
        logic [FOCAL_W-1:0] center_y;
    } dpb_cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_BITS-1:0] depth;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } dpb_in_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [DEPTH_BITS-1:0]     point_z;
        logic [COLOR_BITS-1:0]     out_red;
        logic [COLOR_BITS-1:0]     out_green;
        logic [COLOR_BITS-1:0]     out_blue;
    } dpb_out_t;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } dpb_side_t;

endpackage

FILE: rtl/core/dpb_regs.sv
// ----------------------------------------------------------------------------
// dpb_regs
// APB register file holding the camera intrinsics.
// ----------------------------------------------------------------------------
module dpb_regs
    import dpb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output dpb_cfg_t          cfg
);

    dpb_cfg_t       cfg_reg;
    dpb_cfg_t       cfg_next;
    dpb_reg_index_t idx;
    logic           wen;
    logic [FOCAL_W-1:0] wval;

    assign idx    = dpb_reg_index_t'(paddr[ADDR_W-1:2]);
    assign wen    = psel && penable && pwrite;
    assign wval   = pwdata[FOCAL_W-1:0];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wen)
        begin
            unique case (idx)
                REG_FOCAL_X:  cfg_next.focal_x  = wval;
                REG_FOCAL_Y:  cfg_next.focal_y  = wval;
                REG_CENTER_X: cfg_next.center_x = wval;
                REG_CENTER_Y: cfg_next.center_y = wval;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FOCAL_X:  prdata = DATA_W'(cfg_reg.focal_x);
            REG_FOCAL_Y:  prdata = DATA_W'(cfg_reg.focal_y);
            REG_CENTER_X: prdata = DATA_W'(cfg_reg.center_x);
            REG_CENTER_Y: prdata = DATA_W'(cfg_reg.center_y);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x  <= FOCAL_X_RESET;
            cfg_reg.focal_y  <= FOCAL_Y_RESET;
            cfg_reg.center_x <= CENTER_X_RESET;
            cfg_reg.center_y <= CENTER_Y_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/dpb_front.sv
// ----------------------------------------------------------------------------
// dpb_front
// Two-stage front end of one axis: offset from the principal point, then the
// magnitude of the offset times depth.
// ----------------------------------------------------------------------------
module dpb_front
    import dpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [COORD_BITS-1:0] coord,
    input  logic [FOCAL_W-1:0]    center,
    input  logic [DEPTH_BITS-1:0] depth,
    output logic [PROD_W-1:0]     mag,
    output logic                  neg
);

    logic [DIFF_W-1:0]     diff;
    logic [MAG_W-1:0]      abs_next;
    logic [MAG_W-1:0]      abs_reg;
    logic                  neg1_reg;
    logic [DEPTH_BITS-1:0] depth1_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [PROD_W-1:0]     prod_reg;
    logic                  neg2_reg;

    assign diff      = DIFF_W'({coord, {FRAC_BITS{1'b0}}}) - DIFF_W'(center);
    assign abs_next  = diff[DIFF_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
    assign prod_next = PROD_W'(abs_reg) * PROD_W'(depth1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_reg    <= abs_next;
            neg1_reg   <= diff[DIFF_W-1];
            depth1_reg <= depth;
            prod_reg   <= prod_next;
            neg2_reg   <= neg1_reg;
        end
    end

    assign mag = prod_reg;
    assign neg = neg2_reg;

endmodule

FILE: rtl/core/dpb_div.sv
// ----------------------------------------------------------------------------
// dpb_div
// Pipelined restoring divider, one quotient bit per stage, followed by sign
// restore and saturation to the signed point range.
// ----------------------------------------------------------------------------
module dpb_div
    import dpb_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [PROD_W-1:0]         mag,
    input  logic                      neg,
    input  logic [FOCAL_W-1:0]        focal,
    output logic signed [POINT_W-1:0] result
);

    localparam logic [SAT_W-1:0] POS_LIMIT = SAT_W'(POINT_MAX);
    localparam logic [SAT_W-1:0] NEG_LIMIT = SAT_W'(POINT_MIN);

    logic [FOCAL_W-1:0]    rem_reg  [DIV_STEPS];
    logic [FOCAL_W-1:0]    rem_next [DIV_STEPS];
    logic [DIVIDEND_W-1:0] work_reg [DIV_STEPS];
    logic [DIVIDEND_W-1:0] work_next[DIV_STEPS];
    logic [DIV_STEPS-1:0]  neg_reg;
    logic [DIV_STEPS-1:0]  zero_reg;
    logic [POINT_W-1:0]    res_reg;
    logic [POINT_W-1:0]    res_next;
    logic [SAT_W-1:0]      quot;

    always_comb
    begin
        logic [FOCAL_W:0]      trial;
        logic [FOCAL_W-1:0]    rem_in;
        logic [DIVIDEND_W-1:0] work_in;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                work_in = {mag, {FRAC_BITS{1'b0}}};
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                work_in = work_reg[k-1];
            end
            trial = {rem_in, work_in[DIVIDEND_W-1]};
            if (trial >= {1'b0, focal})
            begin
                rem_next[k]  = FOCAL_W'(trial - {1'b0, focal});
                work_next[k] = {work_in[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = trial[FOCAL_W-1:0];
                work_next[k] = {work_in[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign quot = SAT_W'(work_reg[DIV_STEPS-1]);

    always_comb
    begin
        priority if (zero_reg[DIV_STEPS-1])
        begin
            res_next = '0;
        end
        else if (!neg_reg[DIV_STEPS-1])
        begin
            res_next = (quot > POS_LIMIT) ? POINT_MAX : quot[POINT_W-1:0];
        end
        else
        begin
            res_next = (quot > NEG_LIMIT) ? POINT_MIN : POINT_W'(-quot[POINT_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                work_reg[k] <= work_next[k];
            end
            neg_reg  <= {neg_reg[DIV_STEPS-2:0], neg};
            zero_reg <= {zero_reg[DIV_STEPS-2:0], (mag == '0)};
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule

FILE: rtl/core/depth_pixel_backprojection_unit.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// Back-projects depth pixels through a pinhole camera model into points.
//
//   channel  | signals                       | direction | content
//   pix      | pix_valid, pix_stall, pix_data | in        | column, row, depth, color
//   pt       | pt_valid, pt_stall, pt_data    | out       | x, y, z, color
//   apb      | psel ... pready                | in/out    | focal lengths, center
//
// One request enters per cycle while no point stalls; it passes the input
// register, the front end, the one-bit-per-stage divider and the result register.
// Requests with zero depth are taken and produce no point.
// A stalled point freezes the whole pipeline: pix_stall is pt_stall while pt_valid.
// Reset clears the valid bits and loads the default intrinsics.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit
    import dpb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  dpb_in_t           pix_data,
    output logic              pt_valid,
    input  logic              pt_stall,
    output dpb_out_t          pt_data
);

    localparam int SIDE_STAGES = DIV_STEPS + 3;

    dpb_cfg_t cfg;
    logic     en;

    dpb_in_t                 pix_reg;
    logic                    v0_reg;
    dpb_side_t               side_reg [SIDE_STAGES];
    logic [SIDE_STAGES-1:0]  vld_reg;

    logic [PROD_W-1:0]         mag_x;
    logic [PROD_W-1:0]         mag_y;
    logic                      neg_x;
    logic                      neg_y;
    logic signed [POINT_W-1:0] res_x;
    logic signed [POINT_W-1:0] res_y;

    assign en        = !(pt_valid && pt_stall);
    assign pix_stall = !en;

    dpb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            vld_reg <= '0;
        end
        else if (en)
        begin
            v0_reg  <= pix_valid && (pix_data.depth != '0);
            vld_reg <= {vld_reg[SIDE_STAGES-2:0], v0_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg           <= pix_data;
            side_reg[0].depth <= pix_reg.depth;
            side_reg[0].red   <= pix_reg.red;
            side_reg[0].green <= pix_reg.green;
            side_reg[0].blue  <= pix_reg.blue;
            for (int k = 1; k < SIDE_STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    dpb_front u_front_x (
        .clk    (clk),
        .en     (en),
        .coord  (pix_reg.column),
        .center (cfg.center_x),
        .depth  (pix_reg.depth),
        .mag    (mag_x),
        .neg    (neg_x)
    );

    dpb_front u_front_y (
        .clk    (clk),
        .en     (en),
        .coord  (pix_reg.row),
        .center (cfg.center_y),
        .depth  (pix_reg.depth),
        .mag    (mag_y),
        .neg    (neg_y)
    );

    dpb_div u_div_x (
        .clk    (clk),
        .en     (en),
        .mag    (mag_x),
        .neg    (neg_x),
        .focal  (cfg.focal_x),
        .result (res_x)
    );

    dpb_div u_div_y (
        .clk    (clk),
        .en     (en),
        .mag    (mag_y),
        .neg    (neg_y),
        .focal  (cfg.focal_y),
        .result (res_y)
    );

    assign pt_valid          = vld_reg[SIDE_STAGES-1];
    assign pt_data.point_x   = res_x;
    assign pt_data.point_y   = res_y;
    assign pt_data.point_z   = side_reg[SIDE_STAGES-1].depth;
    assign pt_data.out_red   = side_reg[SIDE_STAGES-1].red;
    assign pt_data.out_green = side_reg[SIDE_STAGES-1].green;
    assign pt_data.out_blue  = side_reg[SIDE_STAGES-1].blue;

`ifndef SYNTHESIS
    a_point_has_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid |-> (pt_data.point_z != '0))
        else $error("point delivered with zero depth");

    a_zero_depth_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall && (pix_data.depth == '0)) |=> !v0_reg)
        else $error("zero-depth request entered the pipeline");

    a_zero_focal_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_valid && (cfg.focal_x == '0)) |->
        ((pt_data.point_x == POINT_MAX) || (pt_data.point_x == POINT_MIN) ||
         (pt_data.point_x == '0)))
        else $error("zero focal length did not saturate");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_valid && pt_stall) |=> (pt_valid && $stable(vld_reg)))
        else $error("pipeline moved while the output was stalled");
`endif

endmodule

FILE: tb/tb_depth_pixel_backprojection_unit.sv
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection_unit
// Self-checking testbench for the depth pixel back-projection unit. Pixel
// requests are driven with random gaps while the point side stalls at random.
// Each accepted request with nonzero depth is projected by an in-bench
// fixed-point pinhole model and the expected point is queued, and every point
// that leaves the block is checked field by field against the oldest queued
// point. The camera intrinsics are rewritten over the APB port between phases
// and read back, covering reset values, extreme values, zero focal lengths and
// random settings.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection_unit;
    import dpb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DRAIN_CYCLES = DIV_STEPS + 4 + 20;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     IDLE_PCT     = 12;
    localparam longint SAT_HI       = 64'sd2147483647;
    localparam longint SAT_LO       = -64'sd2147483648;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              pix_valid = 1'b0;
    logic              pix_stall;
    dpb_in_t           pix_data  = '0;
    logic              pt_valid;
    logic              pt_stall  = 1'b0;
    dpb_out_t          pt_data;

    dpb_cfg_t intrinsics;
    dpb_out_t pending_points[$];
    dpb_out_t oldest_point;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       throttle       = 1'b1;

    depth_pixel_backprojection_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .pix_data (pix_data),
        .pt_valid (pt_valid),
        .pt_stall (pt_stall),
        .pt_data  (pt_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** depth_pixel_backprojection_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pt_stall <= throttle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic logic signed [POINT_W-1:0] project_axis(longint coord, longint depth,
                                                                longint center, longint focal);
        longint num;
        longint q;
        num = (coord * 16 - center) * depth * 16;
        if (focal == 0)
        begin
            q = (num > 0) ? SAT_HI : ((num < 0) ? SAT_LO : 0);
        end
        else
        begin
            q = num / focal;
            if (q > SAT_HI)
            begin
                q = SAT_HI;
            end
            else if (q < SAT_LO)
            begin
                q = SAT_LO;
            end
        end
        return q[POINT_W-1:0];
    endfunction

    function automatic dpb_out_t backproject_pixel(dpb_in_t px);
        dpb_out_t pt;
        pt.point_x   = project_axis(px.column, px.depth, intrinsics.center_x, intrinsics.focal_x);
        pt.point_y   = project_axis(px.row, px.depth, intrinsics.center_y, intrinsics.focal_y);
        pt.point_z   = px.depth;
        pt.out_red   = px.red;
        pt.out_green = px.green;
        pt.out_blue  = px.blue;
        return pt;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && pt_valid && !pt_stall)
        begin
            if (pending_points.size() == 0)
            begin
                report_mismatch($sformatf("point with none expected x=%0d y=%0d z=%0d",
                                          pt_data.point_x, pt_data.point_y, pt_data.point_z));
            end
            else
            begin
                oldest_point = pending_points.pop_front();
                if (pt_data.point_x !== oldest_point.point_x)
                    report_mismatch($sformatf("point_x got %0d want %0d",
                                              pt_data.point_x, oldest_point.point_x));
                if (pt_data.point_y !== oldest_point.point_y)
                    report_mismatch($sformatf("point_y got %0d want %0d",
                                              pt_data.point_y, oldest_point.point_y));
                if (pt_data.point_z !== oldest_point.point_z)
                    report_mismatch($sformatf("point_z got %0d want %0d",
                                              pt_data.point_z, oldest_point.point_z));
                if (pt_data.out_red !== oldest_point.out_red)
                    report_mismatch($sformatf("out_red got %0d want %0d",
                                              pt_data.out_red, oldest_point.out_red));
                if (pt_data.out_green !== oldest_point.out_green)
                    report_mismatch($sformatf("out_green got %0d want %0d",
                                              pt_data.out_green, oldest_point.out_green));
                if (pt_data.out_blue !== oldest_point.out_blue)
                    report_mismatch($sformatf("out_blue got %0d want %0d",
                                              pt_data.out_blue, oldest_point.out_blue));
            end
        end
    end

    task automatic send_pixel(dpb_in_t px);
        while (throttle && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        @(posedge clk);
        while (pix_stall)
        begin
            @(posedge clk);
        end
        if (px.depth != 0)
        begin
            pending_points.push_back(backproject_pixel(px));
        end
    endtask

    task automatic send_directed(int col, int row, int depth, int r, int g, int b);
        dpb_in_t px;
        px.column = COORD_BITS'(col);
        px.row    = COORD_BITS'(row);
        px.depth  = DEPTH_BITS'(depth);
        px.red    = COLOR_BITS'(r);
        px.green  = COLOR_BITS'(g);
        px.blue   = COLOR_BITS'(b);
        send_pixel(px);
    endtask

    task automatic wait_drained();
        int quiet;
        quiet = 0;
        pix_valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        while (quiet < DRAIN_CYCLES)
        begin
            @(posedge clk);
            if (!pt_stall)
            begin
                quiet++;
            end
        end
    endtask

    task automatic apb_access(dpb_reg_index_t idx, logic write, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_intrinsic(dpb_reg_index_t idx, logic [DATA_W-1:0] value);
        logic [FOCAL_W-1:0] field;
        field = value[FOCAL_W-1:0];
        apb_access(idx, 1'b1, value);
        case (idx)
            REG_FOCAL_X:  intrinsics.focal_x  = field;
            REG_FOCAL_Y:  intrinsics.focal_y  = field;
            REG_CENTER_X: intrinsics.center_x = field;
            REG_CENTER_Y: intrinsics.center_y = field;
            default:      ;
        endcase
        check_intrinsic(idx, field);
    endtask

    task automatic check_intrinsic(dpb_reg_index_t idx, logic [FOCAL_W-1:0] want);
        apb_access(idx, 1'b0, '0);
        if (prdata !== DATA_W'(want))
        begin
            report_mismatch($sformatf("register %s read %0d want %0d",
                                      idx.name(), prdata, want));
        end
    endtask

    task automatic set_intrinsics(logic [DATA_W-1:0] fx, logic [DATA_W-1:0] fy,
                                  logic [DATA_W-1:0] cx, logic [DATA_W-1:0] cy);
        wait_drained();
        write_intrinsic(REG_FOCAL_X, fx);
        write_intrinsic(REG_FOCAL_Y, fy);
        write_intrinsic(REG_CENTER_X, cx);
        write_intrinsic(REG_CENTER_Y, cy);
    endtask

    function automatic logic [DATA_W-1:0] random_focal();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return {16'($urandom), 16'd0};
        else if (pick < 20)
            return {16'($urandom), 16'($urandom_range(16, 511))};
        return {16'($urandom), 16'($urandom_range(1000, 65535))};
    endfunction

    function automatic dpb_in_t random_pixel();
        dpb_in_t px;
        int      pick;
        px.column = ($urandom_range(0, 19) == 0) ? {COORD_BITS{$urandom_range(0, 1) == 1}}
                                                 : COORD_BITS'($urandom);
        px.row    = ($urandom_range(0, 19) == 0) ? {COORD_BITS{$urandom_range(0, 1) == 1}}
                                                 : COORD_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10)
            px.depth = '0;
        else if (pick < 40)
            px.depth = DEPTH_BITS'($urandom_range(1, 255));
        else if (pick < 50)
            px.depth = DEPTH_BITS'($urandom_range(65000, 65535));
        else
            px.depth = DEPTH_BITS'($urandom_range(1, 65535));
        px.red   = 8'($urandom);
        px.green = 8'($urandom);
        px.blue  = 8'($urandom);
        return px;
    endfunction

    task automatic test_reset_intrinsics();
        check_intrinsic(REG_FOCAL_X, FOCAL_X_RESET);
        check_intrinsic(REG_FOCAL_Y, FOCAL_Y_RESET);
        check_intrinsic(REG_CENTER_X, CENTER_X_RESET);
        check_intrinsic(REG_CENTER_Y, CENTER_Y_RESET);
        send_directed(0, 0, 1, 0, 0, 0);
        send_directed(4095, 4095, 65535, 255, 255, 255);
        send_directed(320, 240, 1000, 18, 52, 200);
        send_directed(0, 4095, 0, 255, 0, 255);
        send_directed(4095, 0, 65535, 1, 128, 254);
    endtask

    task automatic test_intrinsic_extremes();
        set_intrinsics(32'd16, 32'd65535, 32'd0, 32'd65535);
        send_directed(4095, 0, 65535, 7, 7, 7);
        send_directed(0, 4095, 1, 99, 3, 44);
        send_directed(4095, 4095, 0, 0, 0, 0);
        set_intrinsics(32'd16, 32'd16, 32'd32768, 32'd32768);
        send_directed(0, 0, 65535, 10, 20, 30);
        send_directed(4095, 4095, 65535, 30, 20, 10);
        send_directed(2048, 2048, 40000, 5, 6, 7);
    endtask

    task automatic test_focal_zero();
        set_intrinsics(32'd0, 32'd0, 32'd65535, 32'd0);
        send_directed(0, 0, 500, 1, 2, 3);
        send_directed(4095, 4095, 65535, 4, 5, 6);
        send_directed(100, 0, 1, 200, 100, 50);
    endtask

    task automatic test_random_pixels();
        for (int phase = 0; phase < 8; phase++)
        begin
            set_intrinsics(random_focal(), random_focal(), $urandom, $urandom);
            throttle = (phase != 4);
            for (int n = 0; n < 118; n++)
            begin
                send_pixel(random_pixel());
            end
        end
        throttle = 1'b1;
    endtask

    initial
    begin
        intrinsics = '{FOCAL_X_RESET, FOCAL_Y_RESET, CENTER_X_RESET, CENTER_Y_RESET};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_intrinsics();
        test_intrinsic_extremes();
        test_focal_zero();
        test_random_pixels();
        wait_drained();
        if (mismatch_count == 0 && pending_points.size() == 0)
        begin
            $display("** depth_pixel_backprojection_unit: PASSED **");
        end
        else
        begin
            $display("** depth_pixel_backprojection_unit: FAILED **");
        end
        $finish;
    end

endmodule
